// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SWMQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swmq assertion failed");

// antecedent implies consequent in the next cycle
`define SWMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swmq assertion failed");

`endif

// ===== rtl/core/swmq_pkg.sv =====
// types and constants of the stack with median query
package swmq_pkg;

    localparam int VAL_W = 17;
    localparam int CLS_W = 2;
    localparam int KEY_W = CLS_W + VAL_W;

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_MEDIAN = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic [CLS_W-1:0] CLS_NEG = 2'd0;
    localparam logic [CLS_W-1:0] CLS_VAL = 2'd1;
    localparam logic [CLS_W-1:0] CLS_POS = 2'd2;

    localparam logic [1:0] MODE_INS_L = 2'd0;
    localparam logic [1:0] MODE_INS_R = 2'd1;
    localparam logic [1:0] MODE_DEL_L = 2'd2;
    localparam logic [1:0] MODE_DEL_R = 2'd3;

    typedef logic [KEY_W-1:0] swmq_key_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [VAL_W-1:0] value;
    } swmq_cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] result_value;
    } swmq_result_t;

    typedef struct packed {
        logic             en;
        logic [1:0]       mode;
        logic [VAL_W-1:0] operand;
    } swmq_op_t;

endpackage

// ===== rtl/core/stack_with_median_query.sv =====
// lifo stack with a running lower median over a sorted cell chain
// a command is registered on acceptance; the run state gives median, full and empty results,
// a successful push gives none; busy holds through the run state, and the pop state for a pop
// the pop path takes the extra pop state for the registered read of the stack memory
// reset clears the entry count and control; no result is pending after reset
// the result strobe lasts one cycle and the receiver cannot stall it
module stack_with_median_query
    import swmq_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  swmq_cmd_t    cmd,
    output logic         done,
    output swmq_result_t result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             done_reg;
    logic             done_next;
    swmq_result_t     result_reg;
    swmq_result_t     result_next;
    swmq_cmd_t        cmd_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic [VAL_W-1:0] mem [STACK_DEPTH];

    logic             accept;
    logic             full;
    logic             empty;
    logic             wr_en;
    logic             rd_en;
    logic [CW-1:0]    top_idx;
    swmq_op_t         op;
    logic [VAL_W-1:0] median;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign empty   = (count_reg == '0);
    assign top_idx = count_reg - CW'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        op.en       = 1'b0;
        op.mode     = count_reg[0] ? MODE_INS_R : MODE_INS_L;
        op.operand  = cmd_reg.value;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_IDLE;
                case (cmd_reg.action)
                    ACT_PUSH:
                    begin
                        if (full)
                        begin
                            done_next   = 1'b1;
                            result_next = '{status: STAT_FULL, result_value: '0};
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            op.en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_POP:
                    begin
                        if (empty)
                        begin
                            done_next   = 1'b1;
                            result_next = '{status: STAT_EMPTY, result_value: '0};
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_POP;
                        end
                    end
                    ACT_MEDIAN:
                    begin
                        done_next = 1'b1;
                        if (empty)
                        begin
                            result_next = '{status: STAT_EMPTY, result_value: '0};
                        end
                        else
                        begin
                            result_next = '{status: STAT_OK, result_value: median};
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_POP:
            begin
                state_next  = ST_IDLE;
                op.en       = 1'b1;
                op.mode     = count_reg[0] ? MODE_DEL_R : MODE_DEL_L;
                op.operand  = rd_data_reg;
                count_next  = top_idx;
                done_next   = 1'b1;
                result_next = '{status: STAT_OK, result_value: rd_data_reg};
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= cmd_reg.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[top_idx[AW-1:0]];
        end
    end

    swmq_chain #(
        .DEPTH (STACK_DEPTH),
        .CW    (CW)
    ) u_chain (
        .clk    (clk),
        .op     (op),
        .count  (count_reg),
        .median (median)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/swmq_cell.sv =====
// one cell of the sorted chain
module swmq_cell
    import swmq_pkg::*;
#(
    parameter int POS_W = 11,
    parameter int POS   = 0
)
(
    input  logic             clk,
    input  swmq_op_t         op,
    input  logic [POS_W-1:0] first_pos,
    input  logic [POS_W-1:0] end_pos,
    input  swmq_key_t        left_key,
    input  swmq_key_t        right_key,
    output swmq_key_t        key
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic [CLS_W-1:0] cls;
    swmq_key_t        opnd_key;

    always_comb
    begin
        if (MY_POS < first_pos)
        begin
            cls = CLS_NEG;
        end
        else if (MY_POS >= end_pos)
        begin
            cls = CLS_POS;
        end
        else
        begin
            cls = CLS_VAL;
        end
    end

    assign key      = {cls, val_reg};
    assign opnd_key = {CLS_VAL, op.operand};

    always_comb
    begin
        val_next = val_reg;
        case (op.mode)
            MODE_INS_L:
            begin
                if (right_key < opnd_key)
                begin
                    val_next = right_key[VAL_W-1:0];
                end
                else if (key < opnd_key)
                begin
                    val_next = op.operand;
                end
            end
            MODE_INS_R:
            begin
                if (left_key >= opnd_key)
                begin
                    val_next = left_key[VAL_W-1:0];
                end
                else if (key >= opnd_key)
                begin
                    val_next = op.operand;
                end
            end
            MODE_DEL_L:
            begin
                if (right_key > opnd_key)
                begin
                    val_next = right_key[VAL_W-1:0];
                end
            end
            MODE_DEL_R:
            begin
                if (left_key < opnd_key)
                begin
                    val_next = left_key[VAL_W-1:0];
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            val_reg <= val_next;
        end
    end

endmodule

// ===== rtl/core/swmq_chain.sv =====
// sorted cell chain with the lower median held at a fixed center cell
module swmq_chain
    import swmq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int CW    = 11
)
(
    input  logic             clk,
    input  swmq_op_t         op,
    input  logic [CW-1:0]    count,
    output logic [VAL_W-1:0] median
);

    localparam int NL = ((DEPTH - 1) >> 1) + 1;

    swmq_key_t     keys [DEPTH];
    logic [CW:0]   lo_sum;
    logic [CW-1:0] lo_cnt;
    logic [CW-1:0] hi_cnt;
    logic [CW-1:0] first_pos;
    logic [CW-1:0] end_pos;

    // lower part holds ranks up to the median, upper part the rest
    assign lo_sum    = {1'b0, count} + (CW + 1)'(1);
    assign lo_cnt    = lo_sum[CW:1];
    assign hi_cnt    = count >> 1;
    assign first_pos = CW'(NL) - lo_cnt;
    assign end_pos   = CW'(NL) + hi_cnt;

    for (genvar p = 0; p < DEPTH; p++)
    begin : g_cell
        swmq_key_t left_key;
        swmq_key_t right_key;

        if (p == 0)
        begin : g_left_end
            assign left_key = {CLS_NEG, {VAL_W{1'b0}}};
        end
        else
        begin : g_left
            assign left_key = keys[p-1];
        end

        if (p == DEPTH - 1)
        begin : g_right_end
            assign right_key = {CLS_POS, {VAL_W{1'b0}}};
        end
        else
        begin : g_right
            assign right_key = keys[p+1];
        end

        swmq_cell #(
            .POS_W (CW),
            .POS   (p)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .first_pos (first_pos),
            .end_pos   (end_pos),
            .left_key  (left_key),
            .right_key (right_key),
            .key       (keys[p])
        );
    end

    assign median = keys[NL-1][VAL_W-1:0];

endmodule

// ===== rtl/core/swmq_checker.sv =====
// port checker for the stack with median query and its bind
`include "assert_macros.svh"

module swmq_checker
    import swmq_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input swmq_cmd_t    cmd,
    input logic         done,
    input swmq_result_t result
);

    logic cmd_seen;

    assign cmd_seen = (cmd.action == ACT_PUSH) || (cmd.action != ACT_PUSH);

    `SWMQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy && cmd_seen, busy)
    `SWMQ_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `SWMQ_ASSERT_SAME(a_done_after_busy, clk, rst_n, done, $past(busy))
    `SWMQ_ASSERT_SAME(a_fail_zero, clk, rst_n, done && (result.status != STAT_OK),
                      result.result_value == '0)

endmodule

bind stack_with_median_query swmq_checker u_swmq_checker (.*);
